// ===== rtl/tcct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcct_pkg
// Shared types and constants for the three-channel compare timer.
// ----------------------------------------------------------------------------
package tcct_pkg;

  localparam int unsigned CHANNELS   = 3;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned NS_W       = 32;
  localparam int unsigned HZ_W       = 30;
  localparam int unsigned PROD_W     = NS_W + HZ_W;
  localparam int unsigned MUL_W      = 2 * NS_W;
  localparam int unsigned CLK_W      = 31;
  localparam int unsigned MASK_W     = 3;

  localparam logic [HZ_W-1:0] NS_PER_SEC   = HZ_W'(1000000000);
  localparam logic [HZ_W-1:0] HZ_RESET     = HZ_W'(100000000);
  // floor(2^61 / 1e9), reciprocal of one billion scaled by 2^61
  localparam logic [NS_W-1:0] RECIP_SEC    = NS_W'(64'd2305843009);
  // 2^31 * 1e9, smallest product whose clock count does not fit 31 bits
  localparam logic [PROD_W-1:0] CLK_LIMIT  = PROD_W'(64'd2147483648000000000);

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_BUSY = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_ACK   = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } ctrl_state_e;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_EST,
    CV_BACK,
    CV_FIX
  } conv_phase_e;

  typedef struct packed {
    logic [1:0]      operation;
    logic [CH_W-1:0] channel;
    logic [NS_W-1:0] span_ns;
    logic            periodic;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [MASK_W-1:0]     fired_mask;
    logic [MASK_W-1:0]     pending_mask;
    logic [COUNT_BITS-1:0] count_value;
  } out_item_t;

  // conversion unit result, valid for one cycle with done
  typedef struct packed {
    logic             done;
    logic             bad;
    logic [CLK_W-1:0] clocks;
  } conv_res_t;

endpackage

// ===== rtl/three_channel_compare_timer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_compare_timer_top
// 32-bit main counter with three compare channels and hardware period reload.
// ----------------------------------------------------------------------------
// Tick, stop, acknowledge and refused start items load their result in the
// transfer cycle and a new item is taken every cycle while the result
// register drains. A start that passes the channel and busy checks holds the
// input from its transfer until its result is loaded: the shared 32x32
// multiplier forms interval * clock_hz in the transfer cycle, then a
// reciprocal multiply estimates the quotient by one billion, a multiply back
// gives the remainder and up to three compare and subtract steps correct the
// estimate. A clock count that does not fit 31 bits is refused at the
// estimate step. clock_hz is written through the config channel, which is
// always ready and must only be written while the block is idle.
module three_channel_compare_timer_top import tcct_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [HZ_W-1:0] cfg_data_i
);

  ctrl_state_e state_q, state_d;

  logic [HZ_W-1:0]       hz_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  count_en_q, count_en_d;
  logic [COUNT_BITS-1:0] cmp_q [CHANNELS];
  logic [COUNT_BITS-1:0] cmp_d [CHANNELS];
  logic [CLK_W-1:0]      period_q [CHANNELS];
  logic [CLK_W-1:0]      period_d [CHANNELS];
  logic [CHANNELS-1:0]   busy_q, busy_d;
  logic [CHANNELS-1:0]   armed_q, armed_d;
  logic [CHANNELS-1:0]   reload_q, reload_d;
  logic [CHANNELS-1:0]   pend_q, pend_d;
  logic [CH_W-1:0]       sel_q;
  logic                  per_q;

  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic                  in_fire;
  logic                  ch_ok;
  logic                  conv_go;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CHANNELS-1:0]   fired;
  conv_res_t             conv_res;

  assign in_fire   = in_valid_i & ~in_stall_o;
  assign ch_ok     = in_data_i.channel < CH_W'(CHANNELS);
  assign count_inc = count_q + 1'b1;

  tcct_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_go),
    .ns_i    (in_data_i.span_ns),
    .hz_i    (hz_q),
    .res_o   (conv_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (conv_go) state_d = ST_CONV;
      ST_CONV: if (conv_res.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    conv_go    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = out_valid_q & out_stall_i;
        conv_go    = in_valid_i & ~(out_valid_q & out_stall_i)
                   & (op_e'(in_data_i.operation) == OP_START)
                   & ch_ok & ~busy_q[in_data_i.channel];
      end
      ST_CONV: in_stall_o = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  // channel and counter datapath
  always_comb begin
    logic load;
    logic [1:0] status;
    load       = 1'b0;
    status     = STATUS_OK;
    fired      = '0;
    count_d    = count_q;
    count_en_d = count_en_q;
    busy_d     = busy_q;
    armed_d    = armed_q;
    reload_d   = reload_q;
    pend_d     = pend_q;
    for (int i = 0; i < CHANNELS; i++) begin
      cmp_d[i]    = cmp_q[i];
      period_d[i] = period_q[i];
    end

    if (in_fire) begin
      unique case (op_e'(in_data_i.operation))
        OP_TICK: begin
          load = 1'b1;
          if (count_en_q) begin
            count_d = count_inc;
            for (int i = 0; i < CHANNELS; i++) begin
              if (armed_q[i] && cmp_q[i] == count_inc) begin
                pend_d[i] = 1'b1;
                fired[i]  = 1'b1;
                if (reload_q[i] && period_q[i] != '0)
                  cmp_d[i] = cmp_q[i] + COUNT_BITS'(period_q[i]);
              end
            end
          end
        end
        OP_START: begin
          if (!ch_ok) begin
            load   = 1'b1;
            status = STATUS_BAD;
          end else if (busy_q[in_data_i.channel]) begin
            load   = 1'b1;
            status = STATUS_BUSY;
          end
        end
        OP_STOP: begin
          load = 1'b1;
          if (!ch_ok) begin
            status = STATUS_BAD;
          end else begin
            armed_d[in_data_i.channel]  = 1'b0;
            busy_d[in_data_i.channel]   = 1'b0;
            reload_d[in_data_i.channel] = 1'b0;
            period_d[in_data_i.channel] = '0;
            if (busy_d == '0) count_en_d = 1'b0;
          end
        end
        OP_ACK: begin
          load = 1'b1;
          if (!ch_ok) status = STATUS_BAD;
          else pend_d[in_data_i.channel] = 1'b0;
        end
        default: load = 1'b1;
      endcase
    end

    if (conv_res.done) begin
      load = 1'b1;
      if (conv_res.bad) begin
        status = STATUS_BAD;
      end else begin
        count_en_d      = 1'b1;
        cmp_d[sel_q]    = count_q + COUNT_BITS'(conv_res.clocks);
        period_d[sel_q] = conv_res.clocks;
        reload_d[sel_q] = per_q;
        armed_d[sel_q]  = 1'b1;
        busy_d[sel_q]   = 1'b1;
      end
    end

    // result register frees on a transfer
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    if (load) begin
      out_valid_d        = 1'b1;
      out_d.status       = status;
      out_d.fired_mask   = MASK_W'(fired);
      out_d.pending_mask = MASK_W'(pend_d);
      out_d.count_value  = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hz_q        <= HZ_RESET;
      count_q     <= '0;
      count_en_q  <= 1'b0;
      busy_q      <= '0;
      armed_q     <= '0;
      reload_q    <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cmp_q[i]    <= '0;
        period_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      count_en_q  <= count_en_d;
      busy_q      <= busy_d;
      armed_q     <= armed_d;
      reload_q    <= reload_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < CHANNELS; i++) begin
        cmp_q[i]    <= cmp_d[i];
        period_q[i] <= period_d[i];
      end
      if (cfg_valid_i && cfg_ready_o) hz_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (conv_go) begin
      sel_q <= in_data_i.channel;
      per_q <= in_data_i.periodic;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the counter runs exactly while some channel is busy
  a_enable_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_en_q == (|busy_q))
    else $error("counter enable out of step with busy channels");

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_res.done |-> state_q == ST_CONV)
    else $error("conversion finished outside of conversion state");

  a_conv_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> in_stall_o && !(out_valid_q && !out_stall_i && !$past(conv_go)))
    else $error("input open or stale result during conversion");

  a_start_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_go |=> state_q == ST_CONV && !out_valid_q)
    else $error("start transfer did not enter conversion with empty output");

endmodule

// ===== rtl/tcct_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcct_conv
// Nanosecond to clock conversion on one shared 32x32 multiplier: product with
// clock_hz, reciprocal estimate of the quotient by one billion, multiply back
// and compare-and-subtract correction.
// ----------------------------------------------------------------------------
module tcct_conv import tcct_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NS_W-1:0] ns_i,
  input  logic [HZ_W-1:0] hz_i,
  output conv_res_t       res_o
);

  conv_phase_e       phase_q, phase_d;
  logic              done_q, done_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CLK_W-1:0]  quo_q, quo_d;
  logic              big_q, big_d;

  logic [NS_W-1:0]   mul_a;
  logic [NS_W-1:0]   mul_b;
  logic [MUL_W-1:0]  mul_p;
  logic              too_big;
  logic              rem_ge;

  // operand select for the shared multiplier
  always_comb begin
    unique case (phase_q)
      CV_IDLE: begin
        mul_a = ns_i;
        mul_b = NS_W'(hz_i);
      end
      CV_EST: begin
        mul_a = prod_q[PROD_W-1:PROD_W-NS_W];
        mul_b = RECIP_SEC;
      end
      CV_BACK: begin
        mul_a = NS_W'(quo_q);
        mul_b = NS_W'(NS_PER_SEC);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = MUL_W'(mul_a) * MUL_W'(mul_b);
  assign too_big = prod_q >= CLK_LIMIT;
  assign rem_ge  = prod_q >= PROD_W'(NS_PER_SEC);

  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    prod_d  = prod_q;
    quo_d   = quo_q;
    big_d   = big_q;
    unique case (phase_q)
      CV_IDLE: begin
        if (start_i) begin
          phase_d = CV_EST;
          prod_d  = mul_p[PROD_W-1:0];
        end
      end
      CV_EST: begin
        // estimate never exceeds the quotient and is short by at most three
        quo_d = mul_p[PROD_W-1:CLK_W];
        big_d = too_big;
        if (too_big) begin
          phase_d = CV_IDLE;
          done_d  = 1'b1;
        end else begin
          phase_d = CV_BACK;
        end
      end
      CV_BACK: begin
        prod_d  = prod_q - mul_p[PROD_W-1:0];
        phase_d = CV_FIX;
      end
      CV_FIX: begin
        if (rem_ge) begin
          prod_d = prod_q - PROD_W'(NS_PER_SEC);
          quo_d  = quo_q + 1'b1;
        end else begin
          phase_d = CV_IDLE;
          done_d  = 1'b1;
        end
      end
      default: phase_d = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= CV_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    quo_q  <= quo_d;
    big_q  <= big_d;
  end

  assign res_o.done   = done_q;
  assign res_o.bad    = big_q | (quo_q == '0);
  assign res_o.clocks = quo_q;

endmodule

// ===== tb/three_channel_compare_timer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_compare_timer_top_tb
// Drives tick, start, stop and acknowledge transfers into the compare timer.
// A cycle-free model of the counter and channels predicts every result.
// Each result is checked field by field against the oldest prediction.
// Phases change clock_hz and the idle and stall pressure on both channels.
// ----------------------------------------------------------------------------
module three_channel_compare_timer_top_tb;
  import tcct_pkg::*;

  localparam longint unsigned NS_PER_SECOND  = 64'(NS_PER_SEC);
  localparam longint unsigned MAX_CLOCKS     = (64'd1 << CLK_W) - 1;
  localparam int unsigned     WATCHDOG_LIMIT = 5000;
  localparam int unsigned     RX_HOLD_CYCLES = 300;
  localparam int unsigned     TAIL_CYCLES    = 120;
  localparam int unsigned     MAX_REPORTS    = 50;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  in_item_t        in_data_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_item_t       out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [HZ_W-1:0] cfg_data_i  = '0;

  // timer model state
  logic [HZ_W-1:0]       hz_cfg   = HZ_RESET;
  logic [COUNT_BITS-1:0] count_q  = '0;
  logic                  count_on = 1'b0;
  logic [COUNT_BITS-1:0] cmp_q    [CHANNELS];
  logic [CLK_W-1:0]      period_q [CHANNELS];
  logic [CHANNELS-1:0]   busy_q   = '0;
  logic [CHANNELS-1:0]   armed_q  = '0;
  logic [CHANNELS-1:0]   reload_q = '0;
  logic [CHANNELS-1:0]   pend_q   = '0;

  in_item_t    item_backlog [$];
  out_item_t   due_results  [$];
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_cnt  = 0;
  bit          tx_hold      = 1'b0;
  int unsigned idle_cycles  = 0;
  int unsigned errors       = 0;

  three_channel_compare_timer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic out_item_t advance_timer(in_item_t it);
    out_item_t       res;
    int unsigned     ch;
    longint unsigned clocks;
    res = '0;
    ch  = it.channel;
    if (it.operation == OP_TICK) begin
      if (count_on) begin
        count_q = count_q + 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (armed_q[i] && cmp_q[i] == count_q) begin
            pend_q[i]         = 1'b1;
            res.fired_mask[i] = 1'b1;
            if (reload_q[i] && period_q[i] != '0) cmp_q[i] = cmp_q[i] + period_q[i];
          end
        end
      end
    end else if (ch >= CHANNELS) begin
      res.status = STATUS_BAD;
    end else if (it.operation == OP_START) begin
      clocks = (64'(it.span_ns) * 64'(hz_cfg)) / NS_PER_SECOND;
      if (busy_q[ch]) begin
        res.status = STATUS_BUSY;
      end else if (clocks == 0 || clocks > MAX_CLOCKS) begin
        res.status = STATUS_BAD;
      end else begin
        count_on     = 1'b1;
        cmp_q[ch]    = count_q + COUNT_BITS'(clocks);
        period_q[ch] = CLK_W'(clocks);
        reload_q[ch] = it.periodic;
        armed_q[ch]  = 1'b1;
        busy_q[ch]   = 1'b1;
      end
    end else if (it.operation == OP_STOP) begin
      armed_q[ch]  = 1'b0;
      busy_q[ch]   = 1'b0;
      period_q[ch] = '0;
      reload_q[ch] = 1'b0;
      if (busy_q == '0) count_on = 1'b0;
    end else begin
      pend_q[ch] = 1'b0;
    end
    res.pending_mask = pend_q;
    res.count_value  = count_q;
    return res;
  endfunction

  function automatic in_item_t make_item(op_e op, logic [CH_W-1:0] ch, logic [NS_W-1:0] ns,
                                         logic per);
    in_item_t it;
    it.operation = op;
    it.channel   = ch;
    it.span_ns   = ns;
    it.periodic  = per;
    return it;
  endfunction

  // mostly intervals of a few clocks so that channels match and reload often
  function automatic in_item_t random_item();
    in_item_t        it;
    int unsigned     sel;
    int unsigned     pick;
    longint unsigned ns;
    sel = $urandom_range(99);
    if (sel < 55)      it.operation = OP_TICK;
    else if (sel < 72) it.operation = OP_START;
    else if (sel < 86) it.operation = OP_STOP;
    else               it.operation = OP_ACK;
    it.channel  = ($urandom_range(19) == 0) ? CH_W'(3) : CH_W'($urandom_range(CHANNELS - 1));
    it.periodic = 1'($urandom_range(1));
    pick = $urandom_range(9);
    if (pick < 2 || hz_cfg == '0) begin
      it.span_ns = $urandom();
    end else if (pick < 3) begin
      it.span_ns = $urandom_range(15);
    end else begin
      ns = (64'($urandom_range(12, 1)) * NS_PER_SECOND + hz_cfg - 1) / hz_cfg;
      it.span_ns = (ns > 64'hFFFF_FFFF) ? $urandom() : ns[NS_W-1:0];
    end
    return it;
  endfunction

  task automatic report_field(string field, longint unsigned want, longint unsigned got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // sampled between edges so that the driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (item_backlog.size() != 0 || in_valid_i || due_results.size() != 0);
  endtask

  task automatic write_clock_hz(input logic [HZ_W-1:0] hz);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= hz;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    hz_cfg = hz;
  endtask

  task automatic run_phase(input bit do_write, input logic [HZ_W-1:0] hz,
                           input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned n_items, input bit rx_squeeze,
                           input bit tx_pause);
    wait_drained();
    if (do_write) write_clock_hz(hz);
    tx_idle_pct  <= tx_pct;
    rx_stall_pct <= rx_pct;
    for (int k = 0; k < n_items; k++) item_backlog.push_back(random_item());
    // receiver blocks long enough for the block to back up into its input
    if (rx_squeeze) rx_hold_cnt <= RX_HOLD_CYCLES;
    if (tx_pause) begin
      while (item_backlog.size() > n_items / 2) @(posedge clk_i);
      tx_hold <= 1'b1;
      do @(negedge clk_i);
      while (in_valid_i || due_results.size() != 0);
      tx_hold <= 1'b0;
    end
  endtask

  // input driver, predicts each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) due_results.push_back(advance_timer(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (item_backlog.size() != 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= item_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (rx_hold_cnt != 0) rx_hold_cnt <= rx_hold_cnt - 1;
      out_stall_i <= (rx_hold_cnt != 0) || ($urandom_range(99) < rx_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data_o);
      end else begin
        want = due_results.pop_front();
        if (out_data_o.status !== want.status)
          report_field("status", want.status, out_data_o.status);
        if (out_data_o.fired_mask !== want.fired_mask)
          report_field("fired_mask", want.fired_mask, out_data_o.fired_mask);
        if (out_data_o.pending_mask !== want.pending_mask)
          report_field("pending_mask", want.pending_mask, out_data_o.pending_mask);
        if (out_data_o.count_value !== want.count_value)
          report_field("count_value", want.count_value, out_data_o.count_value);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      cmp_q[i]    = '0;
      period_q[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed part at the reset clock rate: 10 ns per clock
    item_backlog.push_back(make_item(OP_TICK,  2'd0, '0, 1'b0));
    item_backlog.push_back(make_item(OP_STOP,  2'd0, '0, 1'b0));
    item_backlog.push_back(make_item(OP_ACK,   2'd3, '0, 1'b0));
    item_backlog.push_back(make_item(OP_START, 2'd3, 32'd30, 1'b1));
    item_backlog.push_back(make_item(OP_STOP,  2'd3, '0, 1'b0));
    item_backlog.push_back(make_item(OP_START, 2'd0, 32'd0, 1'b0));
    item_backlog.push_back(make_item(OP_START, 2'd0, 32'd9, 1'b0));
    item_backlog.push_back(make_item(OP_START, 2'd0, 32'd30, 1'b1));
    item_backlog.push_back(make_item(OP_START, 2'd0, 32'd30, 1'b0));
    item_backlog.push_back(make_item(OP_START, 2'd1, 32'd50, 1'b0));
    item_backlog.push_back(make_item(OP_START, 2'd2, 32'hFFFF_FFFF, 1'b1));
    repeat (8) item_backlog.push_back(make_item(OP_TICK, 2'd0, '0, 1'b0));
    item_backlog.push_back(make_item(OP_ACK,  2'd0, '0, 1'b0));
    item_backlog.push_back(make_item(OP_ACK,  2'd1, '0, 1'b0));
    item_backlog.push_back(make_item(OP_STOP, 2'd0, '0, 1'b0));
    item_backlog.push_back(make_item(OP_STOP, 2'd1, '0, 1'b0));
    item_backlog.push_back(make_item(OP_STOP, 2'd2, '0, 1'b0));
    item_backlog.push_back(make_item(OP_TICK, 2'd0, '0, 1'b0));

    run_phase(1'b0, HZ_RESET, 0, 0, 120, 1'b1, 1'b0);
    run_phase(1'b1, HZ_W'(30'h3FFF_FFFF), 87, 0, 120, 1'b0, 1'b0);
    run_phase(1'b1, HZ_W'(1), 0, 87, 120, 1'b0, 1'b0);
    run_phase(1'b1, HZ_W'(0), 21, 21, 40, 1'b0, 1'b0);
    run_phase(1'b1, NS_PER_SEC, 0, 0, 120, 1'b0, 1'b1);
    run_phase(1'b1, HZ_W'($urandom_range(30'h3FFF_FFFF, 1)), 21, 21, 120, 1'b0, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, due_results.size());
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
